>>> hdl/srtd_pkg.sv
// Shared types, widths and codes for the scaled timestamp decoder.
// No dependencies; every other file of the block uses this package.
package srtd_pkg;

    // Field widths of the request and response items
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int BITCNT_W = 6;
    localparam int SN_W     = 16;
    localparam int TS_OUT_W = 32;

    // Default timestamp width (valid range 16 to 32)
    localparam int TS_BITS_DEF = 32;

    // Register port
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_LEGACY = 2'd0;

    // Request command codes
    localparam logic [CMD_W-1:0] CMD_RECORD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNSCALED = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SCALED   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEDUCE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COMMIT   = 3'd4;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_LO,
        OP_WLSB,
        OP_DIV,
        OP_MUL,
        OP_DEDUCE,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             eff_zero;
        logic             div_last;
    } dp_stat_t;

endpackage

>>> hdl/srtd_if.sv
// Request and response channel interfaces of the timestamp decoder.
// Depends on srtd_pkg for field widths.
interface srtd_req_if;
    logic                            valid;
    logic                            ready;
    logic [srtd_pkg::CMD_W-1:0]      command;
    logic [srtd_pkg::VALUE_W-1:0]    value;
    logic [srtd_pkg::BITCNT_W-1:0]   bit_count;
    logic [srtd_pkg::SN_W-1:0]       seq_num;

    modport source (output valid, command, value, bit_count, seq_num, input ready);
    modport sink   (input valid, command, value, bit_count, seq_num, output ready);
endinterface

interface srtd_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [srtd_pkg::TS_OUT_W-1:0]   rebuilt_ts;
    logic                            status;

    modport source (output valid, rebuilt_ts, status, input ready);
    modport sink   (input valid, rebuilt_ts, status, output ready);
endinterface

>>> hdl/srtd_dp.sv
// Datapath: decoder context, W-LSB logic, restoring divider, multiplier
// and result register. Driven by srtd_ctrl; depends on srtd_pkg.
module srtd_dp #(
    parameter int TS_BITS = srtd_pkg::TS_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  srtd_pkg::ctrl_cmd_t             ctrl,
    output srtd_pkg::dp_stat_t              stat,
    input  logic                            legacy_mode,
    input  logic [srtd_pkg::CMD_W-1:0]      in_command,
    input  logic [srtd_pkg::VALUE_W-1:0]    in_value,
    input  logic [srtd_pkg::BITCNT_W-1:0]   in_bit_count,
    input  logic [srtd_pkg::SN_W-1:0]       in_seq_num,
    output logic [srtd_pkg::TS_OUT_W-1:0]   out_rebuilt_ts,
    output logic                            out_status
);

    localparam int CNT_W = $clog2(TS_BITS);
    localparam int KW    = srtd_pkg::BITCNT_W;

    // Request fields held for the duration of the work
    logic [srtd_pkg::CMD_W-1:0] cmd_reg,  cmd_next;
    logic [TS_BITS-1:0]         val_reg,  val_next;
    logic [KW-1:0]              k_reg,    k_next;
    logic [srtd_pkg::SN_W-1:0]  sn_reg,   sn_next;

    // Working registers
    logic [TS_BITS-1:0]         work_reg, work_next;
    logic [TS_BITS-1:0]         lo_reg,   lo_next;
    logic [TS_BITS-1:0]         rem_reg,  rem_next;
    logic [TS_BITS-1:0]         quo_reg,  quo_next;
    logic [CNT_W-1:0]           cnt_reg,  cnt_next;
    logic [TS_BITS-1:0]         prod_reg, prod_next;
    logic [srtd_pkg::TS_OUT_W-1:0] res_ts_reg, res_ts_next;
    logic                       res_st_reg, res_st_next;

    // Context
    logic [TS_BITS-1:0]         stride_reg,  stride_next;
    logic [TS_BITS-1:0]         scaled_reg,  scaled_next;
    logic [TS_BITS-1:0]         offset_reg,  offset_next;
    logic [TS_BITS-1:0]         ref_ts_reg,  ref_ts_next;
    logic [srtd_pkg::SN_W-1:0]  ref_sn_reg,  ref_sn_next;
    logic [TS_BITS-1:0]         pstride_reg, pstride_next;
    logic [TS_BITS-1:0]         pscaled_reg, pscaled_next;
    logic [TS_BITS-1:0]         poffset_reg, poffset_next;

    // Combinational helpers
    logic [TS_BITS-1:0]         eff_stride;
    logic                       k_full;
    logic [TS_BITS-1:0]         kmask;
    logic [TS_BITS-1:0]         pval;
    logic [TS_BITS-1:0]         lo_base;
    logic                       wlsb_abs;
    logic [TS_BITS-1:0]         wlsb_val;
    logic [TS_BITS:0]           rem_sh;
    logic [TS_BITS:0]           div_diff;
    logic [TS_BITS-1:0]         mul_a;
    logic [2*TS_BITS-1:0]       prod_full;
    logic signed [srtd_pkg::SN_W:0] sn_diff;
    logic [31:0]                sn_ext;
    logic [TS_BITS-1:0]         mul_ts;

    assign eff_stride = (pstride_reg != '0) ? pstride_reg : stride_reg;
    assign k_full     = (k_reg >= KW'(TS_BITS));
    assign kmask      = ~({TS_BITS{1'b1}} << k_reg);
    assign pval       = (k_reg > KW'(2)) ? ~({TS_BITS{1'b1}} << (k_reg - KW'(2))) : '0;
    assign lo_base    = (cmd_reg == srtd_pkg::CMD_SCALED) ? scaled_reg : ref_ts_reg;
    assign wlsb_abs   = k_full || (legacy_mode && cmd_reg == srtd_pkg::CMD_UNSCALED);
    // value lands in [lo, lo + 2^k - 1] with matching low bits
    assign wlsb_val   = wlsb_abs ? val_reg : (lo_reg + ((val_reg - lo_reg) & kmask));

    // One quotient bit per step
    assign rem_sh     = {rem_reg, quo_reg[TS_BITS-1]};
    assign div_diff   = rem_sh - {1'b0, eff_stride};

    assign mul_a      = (cmd_reg == srtd_pkg::CMD_DEDUCE) ? stride_reg : eff_stride;
    assign prod_full  = {{TS_BITS{1'b0}}, mul_a} * {{TS_BITS{1'b0}}, work_reg};

    assign sn_diff    = signed'({1'b0, sn_reg}) - signed'({1'b0, ref_sn_reg});
    assign sn_ext     = 32'(sn_diff);
    assign mul_ts     = prod_reg + offset_reg;

    always_comb
    begin
        cmd_next     = cmd_reg;
        val_next     = val_reg;
        k_next       = k_reg;
        sn_next      = sn_reg;
        work_next    = work_reg;
        lo_next      = lo_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        prod_next    = prod_reg;
        res_ts_next  = res_ts_reg;
        res_st_next  = res_st_reg;
        stride_next  = stride_reg;
        scaled_next  = scaled_reg;
        offset_next  = offset_reg;
        ref_ts_next  = ref_ts_reg;
        ref_sn_next  = ref_sn_reg;
        pstride_next = pstride_reg;
        pscaled_next = pscaled_reg;
        poffset_next = poffset_reg;

        unique case (ctrl.op)
            srtd_pkg::OP_NONE:
            begin
            end
            srtd_pkg::OP_LOAD:
            begin
                cmd_next = in_command;
                val_next = in_value[TS_BITS-1:0];
                k_next   = in_bit_count;
                sn_next  = in_seq_num;
            end
            srtd_pkg::OP_LO:
            begin
                lo_next = lo_base - pval;
            end
            srtd_pkg::OP_WLSB:
            begin
                work_next = wlsb_val;
                quo_next  = wlsb_val;
                rem_next  = '0;
                cnt_next  = '0;
            end
            srtd_pkg::OP_DIV:
            begin
                if (!div_diff[TS_BITS])
                begin
                    rem_next = div_diff[TS_BITS-1:0];
                end
                else
                begin
                    rem_next = rem_sh[TS_BITS-1:0];
                end
                quo_next = {quo_reg[TS_BITS-2:0], ~div_diff[TS_BITS]};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            srtd_pkg::OP_MUL:
            begin
                prod_next = prod_full[TS_BITS-1:0];
            end
            srtd_pkg::OP_DEDUCE:
            begin
                work_next = scaled_reg + sn_ext[TS_BITS-1:0];
            end
            srtd_pkg::OP_FINISH:
            begin
                res_ts_next = '0;
                res_st_next = 1'b0;
                unique case (cmd_reg)
                    srtd_pkg::CMD_RECORD:
                    begin
                        pstride_next = val_reg;
                    end
                    srtd_pkg::CMD_UNSCALED:
                    begin
                        res_ts_next = srtd_pkg::TS_OUT_W'(work_reg);
                        if (eff_stride != '0)
                        begin
                            pstride_next = eff_stride;
                            pscaled_next = quo_reg;
                            poffset_next = rem_reg;
                        end
                    end
                    srtd_pkg::CMD_SCALED:
                    begin
                        if (eff_stride == '0)
                        begin
                            res_st_next = 1'b1;
                        end
                        else
                        begin
                            res_ts_next  = srtd_pkg::TS_OUT_W'(mul_ts);
                            pstride_next = eff_stride;
                            pscaled_next = work_reg;
                            poffset_next = offset_reg;
                        end
                    end
                    srtd_pkg::CMD_DEDUCE:
                    begin
                        res_ts_next  = srtd_pkg::TS_OUT_W'(mul_ts);
                        pstride_next = stride_reg;
                        pscaled_next = work_reg;
                        poffset_next = offset_reg;
                    end
                    srtd_pkg::CMD_COMMIT:
                    begin
                        ref_ts_next  = val_reg;
                        ref_sn_next  = sn_reg;
                        scaled_next  = pscaled_reg;
                        stride_next  = pstride_reg;
                        offset_next  = poffset_reg;
                        pscaled_next = '0;
                        pstride_next = '0;
                        poffset_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg  <= '0;
            scaled_reg  <= '0;
            offset_reg  <= '0;
            ref_ts_reg  <= '0;
            ref_sn_reg  <= '0;
            pstride_reg <= '0;
            pscaled_reg <= '0;
            poffset_reg <= '0;
        end
        else
        begin
            stride_reg  <= stride_next;
            scaled_reg  <= scaled_next;
            offset_reg  <= offset_next;
            ref_ts_reg  <= ref_ts_next;
            ref_sn_reg  <= ref_sn_next;
            pstride_reg <= pstride_next;
            pscaled_reg <= pscaled_next;
            poffset_reg <= poffset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        k_reg      <= k_next;
        sn_reg     <= sn_next;
        work_reg   <= work_next;
        lo_reg     <= lo_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        res_ts_reg <= res_ts_next;
        res_st_reg <= res_st_next;
    end

    assign stat.cmd      = cmd_reg;
    assign stat.eff_zero = (eff_stride == '0);
    assign stat.div_last = (cnt_reg == CNT_W'(TS_BITS - 1));

    assign out_rebuilt_ts = res_ts_reg;
    assign out_status     = res_st_reg;

endmodule

>>> hdl/srtd_ctrl.sv
// Controller: sequences each request through the datapath and owns the
// request/response handshakes. Depends on srtd_pkg.
module srtd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  srtd_pkg::dp_stat_t   stat,
    output srtd_pkg::ctrl_cmd_t  ctrl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_LO     = 3'd2;
    localparam logic [2:0] S_WLSB   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       req_fire;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign req_fire  = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = srtd_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.op    = srtd_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    srtd_pkg::CMD_UNSCALED:
                    begin
                        state_next = S_LO;
                    end
                    srtd_pkg::CMD_SCALED:
                    begin
                        state_next = stat.eff_zero ? S_FINISH : S_LO;
                    end
                    srtd_pkg::CMD_DEDUCE:
                    begin
                        ctrl.op    = srtd_pkg::OP_DEDUCE;
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_LO:
            begin
                ctrl.op    = srtd_pkg::OP_LO;
                state_next = S_WLSB;
            end
            S_WLSB:
            begin
                ctrl.op = srtd_pkg::OP_WLSB;
                if (stat.cmd == srtd_pkg::CMD_SCALED)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    // no stride: the decoded value is the result, skip the divide
                    state_next = stat.eff_zero ? S_FINISH : S_DIV;
                end
            end
            S_DIV:
            begin
                ctrl.op = srtd_pkg::OP_DIV;
                if (stat.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_MUL:
            begin
                ctrl.op    = srtd_pkg::OP_MUL;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ctrl.op    = srtd_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.op == srtd_pkg::OP_FINISH)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_fire_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg == S_DECODE)
        else $error("accepted request did not move to decode");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !out_free) |=> (state_reg == S_FINISH && out_valid_reg))
        else $error("finish overran a pending response");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !stat.div_last) |=> state_reg == S_DIV)
        else $error("divider left before its last step");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == srtd_pkg::OP_FINISH) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished request produced no response");

endmodule

>>> hdl/scaled_rtp_timestamp_decoder.sv
// Top level of the scaled timestamp decoder: register port, controller and
// datapath. Depends on srtd_pkg, srtd_if, srtd_ctrl and srtd_dp.
//
// Each request yields exactly one response; one request is worked on at a
// time, and the next one is taken while the previous response waits. Steps:
// record, commit and unknown codes go from decode straight to finish;
// decode-from-sequence-number adds the multiply; scaled decode adds the low
// bound, W-LSB and multiply (none with a zero stride); unscaled decode adds
// the low bound, W-LSB and restoring divider, one quotient bit a cycle (no
// divider with no stride). The legacy-absolute bit lives at byte address 0
// of the register port and must be written only while the block is idle.
module scaled_rtp_timestamp_decoder #(
    parameter int TS_BITS = srtd_pkg::TS_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    srtd_req_if.sink                           req,
    srtd_rsp_if.source                         rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srtd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [srtd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [srtd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic                 legacy_reg, legacy_next;
    logic                 cfg_write;
    srtd_pkg::ctrl_cmd_t  ctrl;
    srtd_pkg::dp_stat_t   stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == srtd_pkg::ADDR_LEGACY);
    assign legacy_next = cfg_write ? pwdata[0] : legacy_reg;
    assign prdata    = (paddr == srtd_pkg::ADDR_LEGACY)
                       ? srtd_pkg::APB_DATA_W'(legacy_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            legacy_reg <= 1'b0;
        end
        else
        begin
            legacy_reg <= legacy_next;
        end
    end

    srtd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    srtd_dp #(
        .TS_BITS (TS_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .legacy_mode    (legacy_reg),
        .in_command     (req.command),
        .in_value       (req.value),
        .in_bit_count   (req.bit_count),
        .in_seq_num     (req.seq_num),
        .out_rebuilt_ts (rsp.rebuilt_ts),
        .out_status     (rsp.status)
    );

endmodule

>>> tb/tb.sv
// Testbench for scaled_rtp_timestamp_decoder: directed and random requests checked
// against a built-in timestamp predictor, with random idling on both channels.
// Depends on srtd_pkg, srtd_if and the decoder RTL.
module tb;

    localparam int TSB = srtd_pkg::TS_BITS_DEF;
    localparam logic [31:0] TS_MASK = 32'((64'd1 << TSB) - 64'd1);

    // Codes the block does not define; they must leave the context alone
    localparam logic [srtd_pkg::CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [srtd_pkg::CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [srtd_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_NO_STRIDE = 1'b1;

    // Longest quiet stretch: receiver hold-off plus a slow stall phase plus the
    // divider, well under this.
    localparam int STALL_LIMIT    = 5000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int MAX_PRINTS     = 50;

    typedef struct {
        logic [srtd_pkg::TS_OUT_W-1:0] rebuilt_ts;
        logic                          status;
    } ts_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [srtd_pkg::APB_ADDR_W-1:0] paddr;
    logic [srtd_pkg::APB_DATA_W-1:0] pwdata;
    logic [srtd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    srtd_req_if req_ch ();
    srtd_rsp_if rsp_ch ();

    scaled_rtp_timestamp_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted decoder context
    logic        legacy_mode = 1'b0;
    logic [31:0] ctx_stride  = '0;
    logic [31:0] ctx_scaled  = '0;
    logic [31:0] ctx_offset  = '0;
    logic [31:0] ctx_ref_ts  = '0;
    logic [15:0] ctx_ref_sn  = '0;
    logic [31:0] pend_stride = '0;
    logic [31:0] pend_scaled = '0;
    logic [31:0] pend_offset = '0;

    ts_result_t  expected_ts_q[$];
    logic [31:0] last_predicted_ts = '0;
    int          error_count       = 0;
    int          idle_cycles       = 0;
    int          burst_left        = 0;
    logic        holdoff_trigger   = 1'b0;
    int          hold_left         = 0;
    int          stall_pct         = 0;
    int          stall_phase_left  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // W-LSB: the one value in [anchor-p, anchor+2^k-1-p] whose low k bits match v
    function automatic logic [31:0] window_decode(input logic [31:0] anchor,
                                                  input logic [31:0] v,
                                                  input logic [5:0]  bits);
        logic [63:0] kmask;
        logic [63:0] p;
        logic [31:0] lo;
        if (bits >= TSB)
            return v & TS_MASK;
        kmask = (64'd1 << bits) - 64'd1;
        p = (bits > 2) ? (64'd1 << (bits - 2)) - 64'd1 : 64'd0;
        lo = (anchor - p[31:0]) & TS_MASK;
        return (lo + ((v - lo) & kmask[31:0])) & TS_MASK;
    endfunction

    function automatic ts_result_t predict_timestamp(
        input logic [srtd_pkg::CMD_W-1:0]    cmd,
        input logic [srtd_pkg::VALUE_W-1:0]  value,
        input logic [srtd_pkg::BITCNT_W-1:0] bits,
        input logic [srtd_pkg::SN_W-1:0]     sn);
        ts_result_t         res;
        logic [31:0]        v;
        logic [31:0]        s;
        logic [31:0]        t;
        logic [31:0]        sc;
        logic signed [31:0] sn_delta;
        res.rebuilt_ts = '0;
        res.status = ST_OK;
        v = value & TS_MASK;
        s = (pend_stride != 0) ? pend_stride : ctx_stride;
        case (cmd)
            srtd_pkg::CMD_RECORD:
                pend_stride = v;
            srtd_pkg::CMD_UNSCALED:
            begin
                t = (legacy_mode || bits >= TSB) ? v : window_decode(ctx_ref_ts, v, bits);
                res.rebuilt_ts = t;
                if (s != 0)
                begin
                    pend_offset = t % s;
                    pend_scaled = (t - pend_offset) / s;
                    pend_stride = s;
                end
            end
            srtd_pkg::CMD_SCALED:
            begin
                if (s == 0)
                    res.status = ST_NO_STRIDE;
                else
                begin
                    sc = window_decode(ctx_scaled, v, bits);
                    res.rebuilt_ts = (s * sc + ctx_offset) & TS_MASK;
                    pend_scaled = sc;
                    pend_stride = s;
                    pend_offset = ctx_offset;
                end
            end
            srtd_pkg::CMD_DEDUCE:
            begin
                sn_delta = $signed({16'd0, sn}) - $signed({16'd0, ctx_ref_sn});
                sc = (ctx_scaled + sn_delta) & TS_MASK;
                res.rebuilt_ts = (sc * ctx_stride + ctx_offset) & TS_MASK;
                pend_scaled = sc;
                pend_stride = ctx_stride;
                pend_offset = ctx_offset;
            end
            srtd_pkg::CMD_COMMIT:
            begin
                ctx_ref_ts = v;
                ctx_ref_sn = sn;
                ctx_scaled = pend_scaled;
                ctx_stride = pend_stride;
                ctx_offset = pend_offset;
                pend_scaled = '0;
                pend_stride = '0;
                pend_offset = '0;
            end
            default:
                ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Response first: a response can never belong to the request taken at the same edge
    always @(posedge clk)
    begin : monitor
        ts_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_ts_q.size() == 0)
                report_mismatch("response with no request waiting", rsp_ch.rebuilt_ts, '0);
            else
            begin
                want = expected_ts_q.pop_front();
                if (rsp_ch.rebuilt_ts !== want.rebuilt_ts)
                    report_mismatch("rebuilt_ts", rsp_ch.rebuilt_ts, want.rebuilt_ts);
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", {31'd0, rsp_ch.status}, {31'd0, want.status});
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            want = predict_timestamp(req_ch.command, req_ch.value, req_ch.bit_count,
                                     req_ch.seq_num);
            expected_ts_q.push_back(want);
            last_predicted_ts = want.rebuilt_ts;
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Receiver: stall rate changes in phases; a hold-off request blocks it outright
    always @(negedge clk)
    begin
        if (holdoff_trigger)
        begin
            holdoff_trigger = 1'b0;
            hold_left = HOLDOFF_CYCLES;
        end
        if (stall_phase_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
            stall_phase_left = $urandom_range(16, 200);
        end
        else
            stall_phase_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Called at a falling edge; returns at a falling edge with valid possibly still high
    task automatic send_request(input logic [srtd_pkg::CMD_W-1:0]    cmd,
                                input logic [srtd_pkg::VALUE_W-1:0]  value,
                                input logic [srtd_pkg::BITCNT_W-1:0] bits,
                                input logic [srtd_pkg::SN_W-1:0]     sn);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.value     <= value;
        req_ch.bit_count <= bits;
        req_ch.seq_num   <= sn;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 10);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic wait_for_responses();
        req_ch.valid <= 1'b0;
        while (expected_ts_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_legacy_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= srtd_pkg::ADDR_LEGACY;
        pwdata  <= {{(srtd_pkg::APB_DATA_W-1){1'b0}}, mode};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        legacy_mode = mode;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (prdata !== {{(srtd_pkg::APB_DATA_W-1){1'b0}}, mode})
            report_mismatch("legacy_absolute_mode readback", prdata,
                            {{(srtd_pkg::APB_DATA_W-1){1'b0}}, mode});
    endtask

    task automatic send_noise();
        send_request(srtd_pkg::CMD_W'($urandom_range(0, 7)), $urandom,
                     srtd_pkg::BITCNT_W'($urandom_range(0, 63)), srtd_pkg::SN_W'($urandom));
    endtask

    // One packet: optional stride, one decode, then usually a commit
    task automatic run_packet();
        logic [srtd_pkg::VALUE_W-1:0]  stride_val;
        logic [srtd_pkg::VALUE_W-1:0]  field;
        logic [srtd_pkg::BITCNT_W-1:0] bits;
        logic [srtd_pkg::SN_W-1:0]     sn;
        if ($urandom_range(0, 2) != 0)
        begin
            case ($urandom_range(0, 9))
                0:       stride_val = '0;
                1:       stride_val = 32'd1;
                2:       stride_val = 32'hFFFF_FFFF;
                3:       stride_val = $urandom;
                default: stride_val = $urandom_range(2, 3000);
            endcase
            send_request(srtd_pkg::CMD_RECORD, stride_val, srtd_pkg::BITCNT_W'($urandom),
                         srtd_pkg::SN_W'($urandom));
        end
        case ($urandom_range(0, 7))
            0:       bits = srtd_pkg::BITCNT_W'($urandom_range(0, 63));
            1:       bits = 6'd32;
            default: bits = srtd_pkg::BITCNT_W'($urandom_range(1, 20));
        endcase
        sn = ($urandom_range(0, 7) == 0) ? srtd_pkg::SN_W'($urandom)
                                         : ctx_ref_sn + srtd_pkg::SN_W'($urandom_range(1, 4));
        case ($urandom_range(0, 2))
            0:
            begin
                field = ctx_ref_ts + ctx_stride * $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0)
                    field = field + $urandom_range(0, 40);
                if ($urandom_range(0, 7) == 0)
                    field = $urandom;
                send_request(srtd_pkg::CMD_UNSCALED, field, bits, sn);
            end
            1:
            begin
                field = ($urandom_range(0, 7) == 0) ? $urandom
                                                    : ctx_scaled + $urandom_range(0, 6);
                send_request(srtd_pkg::CMD_SCALED, field, bits, sn);
            end
            default:
                send_request(srtd_pkg::CMD_DEDUCE, $urandom, bits, sn);
        endcase
        // broken packet now and then: no commit
        if ($urandom_range(0, 9) != 0)
            send_request(srtd_pkg::CMD_COMMIT, last_predicted_ts,
                         srtd_pkg::BITCNT_W'($urandom), sn);
    endtask

    task automatic test_directed_cases();
        send_request(srtd_pkg::CMD_UNSCALED, 32'h1234_5678, 6'd32, 16'd0);
        send_request(srtd_pkg::CMD_SCALED, 32'd5, 6'd4, 16'd0);
        send_request(srtd_pkg::CMD_DEDUCE, 32'd0, 6'd1, 16'hFFFF);
        send_request(srtd_pkg::CMD_COMMIT, 32'hFFFF_FFFF, 6'd0, 16'hFFFF);
        send_request(srtd_pkg::CMD_RECORD, 32'hFFFF_FFFF, 6'd63, 16'd0);
        send_request(srtd_pkg::CMD_UNSCALED, 32'hFFFF_FFFE, 6'd0, 16'd0);
        send_request(srtd_pkg::CMD_COMMIT, 32'd0, 6'd0, 16'd0);
        send_request(srtd_pkg::CMD_RECORD, 32'd1, 6'd1, 16'd0);
        send_request(srtd_pkg::CMD_UNSCALED, 32'hFFFF_FFFF, 6'd63, 16'd0);
        send_request(srtd_pkg::CMD_COMMIT, 32'hFFFF_FFFF, 6'd0, 16'd0);
        send_request(srtd_pkg::CMD_RECORD, 32'd160, 6'd0, 16'd0);
        send_request(srtd_pkg::CMD_UNSCALED, 32'd5, 6'd1, 16'd0);
        send_request(srtd_pkg::CMD_UNSCALED, 32'd3, 6'd2, 16'd0);
        send_request(srtd_pkg::CMD_UNSCALED, 32'd7, 6'd3, 16'd0);
        send_request(srtd_pkg::CMD_COMMIT, 32'd320, 6'd0, 16'd1);
        send_request(srtd_pkg::CMD_SCALED, 32'h3F, 6'd6, 16'd2);
        send_request(srtd_pkg::CMD_SCALED, 32'd0, 6'd0, 16'd2);
        send_request(srtd_pkg::CMD_SCALED, 32'hFFFF_FFFF, 6'd32, 16'd2);
        send_request(srtd_pkg::CMD_COMMIT, 32'd1000, 6'd0, 16'hFFFF);
        // sequence number steps of -65535 and 0 against the reference
        send_request(srtd_pkg::CMD_DEDUCE, 32'd0, 6'd0, 16'd0);
        send_request(srtd_pkg::CMD_DEDUCE, 32'hFFFF_FFFF, 6'd0, 16'hFFFF);
        send_request(CMD_RSVD_5, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF);
        send_request(CMD_RSVD_6, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF);
        send_request(CMD_RSVD_7, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF);
        send_request(srtd_pkg::CMD_COMMIT, 32'd0, 6'd0, 16'd0);
    endtask

    task automatic test_legacy_mode();
        wait_for_responses();
        write_legacy_mode(1'b1);
        repeat (60)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                run_packet();
        end
        wait_for_responses();
        write_legacy_mode(1'b0);
    endtask

    task automatic test_random_packets(input int n_packets);
        repeat (n_packets)
        begin
            if ($urandom_range(0, 99) < 12)
                send_noise();
            else
                run_packet();
        end
    endtask

    // Receiver blocked while requests keep coming back to back
    task automatic test_backpressure();
        wait_for_responses();
        @(posedge clk);
        holdoff_trigger = 1'b1;
        @(negedge clk);
        burst_left = 1000;
        repeat (40)
            send_noise();
        burst_left = 0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.command   = srtd_pkg::CMD_RECORD;
        req_ch.value     = '0;
        req_ch.bit_count = '0;
        req_ch.seq_num   = '0;
        rsp_ch.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = srtd_pkg::ADDR_LEGACY;
        pwdata           = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_legacy_mode(1'b0);
        test_directed_cases();
        test_legacy_mode();
        test_random_packets(280);
        test_backpressure();
        test_random_packets(20);
        wait_for_responses();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

>>> scaled_rtp_timestamp_decoder.f
hdl/srtd_pkg.sv
hdl/srtd_if.sv
hdl/srtd_dp.sv
hdl/srtd_ctrl.sv
hdl/scaled_rtp_timestamp_decoder.sv
tb/tb.sv
